// File: hdl/nd_index_linearizer_core_assert.svh
`ifndef ND_INDEX_LINEARIZER_CORE_ASSERT_SVH
`define ND_INDEX_LINEARIZER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the block clock and quiet during reset.
`define NDIL_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nd_index_linearizer_core: port check failed");

// Next-cycle implication, sampled on the block clock and quiet during reset.
`define NDIL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nd_index_linearizer_core: port check failed");

`endif

// File: hdl/ndil_pkg.sv
package ndil_pkg;

   localparam int MAX_RANK        = 4;
   localparam int NUM_DIMS        = 4;
   localparam int DIM_BITS        = 12;
   localparam int IDX_BITS        = 48;
   localparam int RANK_BITS       = 3;
   localparam int CODE_BITS       = 3;
   localparam int ADDR_BITS       = 5;
   localparam int DATA_BITS       = 32;
   localparam int DIM_IDX_BITS    = $clog2(NUM_DIMS);
   localparam int RANK_LIMIT      = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS;
   localparam int DIV_STEPS       = IDX_BITS * (NUM_DIMS - 1);
   localparam int STEPS_PER_STAGE = 4;
   localparam int DIV_STAGES      = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   typedef enum logic [CODE_BITS-1:0] {
      ST_OK,
      ST_COUNT_MISMATCH,
      ST_COMPONENT_LARGE,
      ST_INDEX_LARGE,
      ST_ZERO_DIM
   } status_type;

   typedef enum logic [CODE_BITS-1:0] {
      SHAPE_UNSPECIFIED,
      SHAPE_DONTCARE,
      SHAPE_INVALID,
      SHAPE_ALL_ONES,
      SHAPE_SPECIFIED
   } shape_type;

   typedef enum logic [ADDR_BITS-3:0] {
      REG_RANK,
      REG_SIZE0,
      REG_SIZE1,
      REG_SIZE2,
      REG_SIZE3
   } reg_index_type;

   // One slot of the division pipeline.
   typedef struct packed {
      logic                               valid;
      logic                               op;
      logic [RANK_BITS-1:0]               count;
      logic [NUM_DIMS-1:0][DIM_BITS-1:0]  coord;
      logic [IDX_BITS-1:0]                x;
      logic [IDX_BITS-1:0]                quo;
      logic [DIM_BITS-1:0]                rem;
      logic [DIM_BITS-1:0]                r0;
      logic [DIM_BITS-1:0]                r1;
      logic [IDX_BITS-1:0]                q0;
      logic [IDX_BITS-1:0]                q1;
   } div_type;

   // Slot after the multiply stage.
   typedef struct packed {
      logic                               valid;
      status_type                         status;
      logic [NUM_DIMS-1:0][IDX_BITS-1:0]  term;
      logic [NUM_DIMS-1:0][IDX_BITS-1:0]  digit;
   } mid_type;

endpackage

// File: hdl/nd_index_linearizer_core.sv
// Converts between a coordinate of up to four dimensions and a linear index,
// first dimension fastest. The block takes one request per clock cycle while
// req_stall is low. The path is 39 registers deep: one input stage, 36
// division stages, one multiply stage and one output stage. The input stage
// loads at the accepting edge itself. The pipeline depth is set by the
// index-to-coordinate path, which divides the 48-bit index by three dimension
// sizes in turn with a restoring divider that resolves four quotient bits per
// stage. All stages move together; they hold only while a result sits in the
// output register and the consumer stalls. Configuration must be written
// while no request is in flight.
module nd_index_linearizer_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [ndil_pkg::RANK_BITS-1:0]  req_coord_count,
   input  logic [ndil_pkg::DIM_BITS-1:0]   req_coord_a,
   input  logic [ndil_pkg::DIM_BITS-1:0]   req_coord_b,
   input  logic [ndil_pkg::DIM_BITS-1:0]   req_coord_c,
   input  logic [ndil_pkg::DIM_BITS-1:0]   req_coord_d,
   input  logic [ndil_pkg::IDX_BITS-1:0]   req_linear_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ndil_pkg::IDX_BITS-1:0]   rsp_linear_out,
   output logic [ndil_pkg::IDX_BITS-1:0]   rsp_out_a,
   output logic [ndil_pkg::IDX_BITS-1:0]   rsp_out_b,
   output logic [ndil_pkg::IDX_BITS-1:0]   rsp_out_c,
   output logic [ndil_pkg::IDX_BITS-1:0]   rsp_out_d,
   output logic [ndil_pkg::IDX_BITS-1:0]   rsp_element_count,
   output logic [ndil_pkg::CODE_BITS-1:0]  rsp_shape_class,
   output logic [ndil_pkg::CODE_BITS-1:0]  rsp_status,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ndil_pkg::ADDR_BITS-1:0]  paddr,
   input  logic [ndil_pkg::DATA_BITS-1:0]  pwdata,
   output logic [ndil_pkg::DATA_BITS-1:0]  prdata,
   output logic                            pready
);
   import ndil_pkg::*;

   // Configuration registers.
   logic [RANK_BITS-1:0]              rank_ff;
   logic [NUM_DIMS-1:0][DIM_BITS-1:0] size_ff;
   logic                              csr_write;

   // Size products, refreshed every cycle. The user must keep configuration
   // static while requests flow; the block does not enforce it. The first use
   // is far down the pipeline, so p01_ff, p012_ff and pall_ff settle before it.
   logic [2*DIM_BITS-1:0] p01_ff;
   logic [3*DIM_BITS-1:0] p012_ff;
   logic [IDX_BITS-1:0]   pall_ff;

   logic [RANK_BITS-1:0]  eff_rank;
   logic                  any_zero;
   logic                  all_ones;
   logic [IDX_BITS-1:0]   product;
   shape_type             shape;

   logic    advance;
   div_type div_ff [DIV_STAGES+1];
   div_type div_in [DIV_STAGES+1];
   mid_type mid_ff;
   mid_type mid_in;

   logic                 rsp_valid_ff;
   logic [IDX_BITS-1:0]  linear_ff;
   logic [NUM_DIMS-1:0][IDX_BITS-1:0] digit_ff;
   logic [IDX_BITS-1:0]  count_ff;
   shape_type            shape_ff;
   status_type           status_ff;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= '0;
         size_ff <= {NUM_DIMS{DIM_BITS'(1)}};
      end else if (csr_write) begin
         unique case (paddr[ADDR_BITS-1:2])
            REG_RANK:  rank_ff    <= pwdata[RANK_BITS-1:0];
            REG_SIZE0: size_ff[0] <= pwdata[DIM_BITS-1:0];
            REG_SIZE1: size_ff[1] <= pwdata[DIM_BITS-1:0];
            REG_SIZE2: size_ff[2] <= pwdata[DIM_BITS-1:0];
            REG_SIZE3: size_ff[3] <= pwdata[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr[ADDR_BITS-1:2])
         REG_RANK:  prdata = DATA_BITS'(rank_ff);
         REG_SIZE0: prdata = DATA_BITS'(size_ff[0]);
         REG_SIZE1: prdata = DATA_BITS'(size_ff[1]);
         REG_SIZE2: prdata = DATA_BITS'(size_ff[2]);
         REG_SIZE3: prdata = DATA_BITS'(size_ff[3]);
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      p01_ff  <= (2*DIM_BITS)'(size_ff[0]) * (2*DIM_BITS)'(size_ff[1]);
      p012_ff <= (3*DIM_BITS)'(p01_ff) * (3*DIM_BITS)'(size_ff[2]);
      pall_ff <= IDX_BITS'(IDX_BITS'(p012_ff) * IDX_BITS'(size_ff[3]));
   end

   // A rank beyond the supported number of dimensions saturates.
   always_comb begin
      eff_rank = (rank_ff > RANK_BITS'(RANK_LIMIT)) ? RANK_BITS'(RANK_LIMIT) : rank_ff;
      any_zero = 1'b0;
      all_ones = 1'b1;
      for (int i = 0; i < NUM_DIMS; i++) begin
         if (RANK_BITS'(i) < eff_rank) begin
            if (size_ff[i] == '0) any_zero = 1'b1;
            if (size_ff[i] != DIM_BITS'(1)) all_ones = 1'b0;
         end
      end
      case (eff_rank)
         3'd0:    product = IDX_BITS'(1);
         3'd1:    product = IDX_BITS'(size_ff[0]);
         3'd2:    product = IDX_BITS'(p01_ff);
         3'd3:    product = IDX_BITS'(p012_ff);
         default: product = pall_ff;
      endcase
      if (eff_rank == '0) shape = SHAPE_UNSPECIFIED;
      else if (eff_rank == RANK_BITS'(1) && size_ff[0] == '0) shape = SHAPE_DONTCARE;
      else if (any_zero) shape = SHAPE_INVALID;
      else if (all_ones) shape = SHAPE_ALL_ONES;
      else shape = SHAPE_SPECIFIED;
   end

   // The whole pipeline holds only when a finished result is being stalled.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Input stage: the index enters the divider as the first dividend.
   always_comb begin
      div_in[0]          = '0;
      div_in[0].valid    = req_valid;
      div_in[0].op       = req_op;
      div_in[0].count    = req_coord_count;
      div_in[0].coord[0] = req_coord_a;
      div_in[0].coord[1] = req_coord_b;
      div_in[0].coord[2] = req_coord_c;
      div_in[0].coord[3] = req_coord_d;
      div_in[0].x        = req_linear_in;
      div_in[0].quo      = req_linear_in;
   end

   // Division stages. The index is divided by size 0, the quotient by
   // size 1 and that quotient by size 2; each division restarts with a
   // clear remainder and keeps the finished remainder and quotient.
   for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
      always_comb begin
         div_type             s;
         logic [DIM_BITS:0]   t;
         logic [DIM_BITS-1:0] dv;
         logic                qb;
         int                  step;
         s = div_ff[g-1];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            step = (g - 1) * STEPS_PER_STAGE + j;
            if (step < DIV_STEPS) begin
               if (step % IDX_BITS == 0 && step != 0) begin
                  if (step / IDX_BITS == 1) begin
                     s.r0 = s.rem;
                     s.q0 = s.quo;
                  end else begin
                     s.r1 = s.rem;
                     s.q1 = s.quo;
                  end
                  s.rem = '0;
               end
               dv = size_ff[DIM_IDX_BITS'(step / IDX_BITS)];
               t  = {s.rem, s.quo[IDX_BITS-1]};
               qb = (t >= {1'b0, dv});
               if (qb) s.rem = DIM_BITS'(t - {1'b0, dv});
               else s.rem = t[DIM_BITS-1:0];
               s.quo = {s.quo[IDX_BITS-2:0], qb};
            end
         end
         div_in[g] = s;
      end
   end

   for (genvar g = 0; g <= DIV_STAGES; g++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[g].valid <= 1'b0;
         end else if (advance) begin
            div_ff[g] <= div_in[g];
         end
      end
   end

   // Multiply stage: range checks, per-dimension terms of the index and
   // selection of the digits. At the end of the divider rem and quo hold
   // the last remainder and quotient.
   always_comb begin
      div_type                           last;
      logic [NUM_DIMS-1:0][IDX_BITS-1:0] factor;
      logic                              bad;
      last       = div_ff[DIV_STAGES];
      factor[0]  = IDX_BITS'(1);
      factor[1]  = IDX_BITS'(size_ff[0]);
      factor[2]  = IDX_BITS'(p01_ff);
      factor[3]  = IDX_BITS'(p012_ff);
      bad        = 1'b0;
      mid_in        = '0;
      mid_in.valid  = last.valid;
      mid_in.status = ST_OK;
      if (!last.op) begin
         if (last.count != eff_rank) begin
            mid_in.status = ST_COUNT_MISMATCH;
         end else begin
            for (int i = 0; i < NUM_DIMS; i++) begin
               if (RANK_BITS'(i) < eff_rank && last.coord[i] >= size_ff[i]) bad = 1'b1;
            end
            if (bad) begin
               mid_in.status = ST_COMPONENT_LARGE;
            end else begin
               for (int i = 0; i < NUM_DIMS; i++) begin
                  if (RANK_BITS'(i) < eff_rank) begin
                     mid_in.term[i] = IDX_BITS'(factor[i] * IDX_BITS'(last.coord[i]));
                  end
               end
            end
         end
      end else if (any_zero) begin
         mid_in.status = ST_ZERO_DIM;
      end else begin
         if (last.x >= product) mid_in.status = ST_INDEX_LARGE;
         case (eff_rank)
            3'd1: begin
               mid_in.digit[0] = last.x;
            end
            3'd2: begin
               mid_in.digit[0] = IDX_BITS'(last.r0);
               mid_in.digit[1] = last.q0;
            end
            3'd3: begin
               mid_in.digit[0] = IDX_BITS'(last.r0);
               mid_in.digit[1] = IDX_BITS'(last.r1);
               mid_in.digit[2] = last.q1;
            end
            3'd4: begin
               mid_in.digit[0] = IDX_BITS'(last.r0);
               mid_in.digit[1] = IDX_BITS'(last.r1);
               mid_in.digit[2] = IDX_BITS'(last.rem);
               mid_in.digit[3] = last.quo;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.valid <= 1'b0;
      end else if (advance) begin
         mid_ff <= mid_in;
      end
   end

   // Output register: the index is the sum of the terms, which are zero
   // for unused dimensions and for every error.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mid_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         linear_ff <= mid_ff.term[0] + mid_ff.term[1] + mid_ff.term[2] + mid_ff.term[3];
         digit_ff  <= mid_ff.digit;
         count_ff  <= (shape == SHAPE_ALL_ONES || shape == SHAPE_SPECIFIED) ? product : '0;
         shape_ff  <= shape;
         status_ff <= mid_ff.status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_linear_out    = linear_ff;
   assign rsp_out_a         = digit_ff[0];
   assign rsp_out_b         = digit_ff[1];
   assign rsp_out_c         = digit_ff[2];
   assign rsp_out_d         = digit_ff[3];
   assign rsp_element_count = count_ff;
   assign rsp_shape_class   = shape_ff;
   assign rsp_status        = status_ff;

endmodule

// File: hdl/ndil_checker.sv
`include "nd_index_linearizer_core_assert.svh"

module ndil_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [ndil_pkg::IDX_BITS-1:0]   rsp_linear_out,
   input logic [ndil_pkg::IDX_BITS-1:0]   rsp_out_a,
   input logic [ndil_pkg::IDX_BITS-1:0]   rsp_out_b,
   input logic [ndil_pkg::IDX_BITS-1:0]   rsp_out_c,
   input logic [ndil_pkg::IDX_BITS-1:0]   rsp_out_d,
   input logic [ndil_pkg::IDX_BITS-1:0]   rsp_element_count,
   input logic [ndil_pkg::CODE_BITS-1:0]  rsp_shape_class,
   input logic [ndil_pkg::CODE_BITS-1:0]  rsp_status
);
   import ndil_pkg::*;

   // A stalled result stays put.
   `NDIL_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_linear_out) && $stable(rsp_out_a) && $stable(rsp_status))

   // Requests are only held back by a stalled result.
   `NDIL_ASSERT_SAME(a_no_idle_stall, !rsp_valid, !req_stall)

   // Shapes without a meaningful size report no elements.
   `NDIL_ASSERT_SAME(a_count_zero, rsp_valid && rsp_shape_class < SHAPE_ALL_ONES, rsp_element_count == 0)

   // A count mismatch returns no index and no digits.
   `NDIL_ASSERT_SAME(a_mismatch_clear, rsp_valid && rsp_status == ST_COUNT_MISMATCH, rsp_linear_out == 0 && rsp_out_a == 0 && rsp_out_d == 0)

   // A zero dimension only comes with an invalid or dontcare shape, digits cleared.
   `NDIL_ASSERT_SAME(a_zero_dim, rsp_valid && rsp_status == ST_ZERO_DIM, (rsp_shape_class == SHAPE_INVALID || rsp_shape_class == SHAPE_DONTCARE) && rsp_out_a == 0 && rsp_out_b == 0 && rsp_out_c == 0)

endmodule

bind nd_index_linearizer_core ndil_checker u_ndil_checker (.*);
